### rtl/dpd_pkg.sv
// shared types and constants for the dual-phase pad debouncer
// no dependencies

package dpd_pkg;

  // pad geometry
  localparam int unsigned ButtonCount = 10;
  localparam int unsigned LineCount   = 5;
  localparam int unsigned IdxW        = $clog2(ButtonCount);

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] DebounceReset = 16'd50;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_MS = 8'd0,
    CFG_DIODE_FIX   = 8'd1
  } cfg_idx_e;

  // buttons whose debounced state flips on one scan, with their new state
  typedef struct packed {
    logic [ButtonCount-1:0] mask;
    logic [ButtonCount-1:0] value;
  } evt_batch_t;

endpackage

### rtl/dpd_track.sv
// per-button debounced state and change stamps, change detection per scan
// depends on dpd_pkg

module dpd_track import dpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 commit_i,
  input  logic [LineCount-1:0] low_lines_i,
  input  logic [LineCount-1:0] high_lines_i,
  input  logic [31:0]          now_ms_i,
  input  logic [15:0]          debounce_ms_i,
  input  logic                 diode_fix_i,
  output evt_batch_t           batch_o
);

  logic [ButtonCount-1:0] state_q, state_d;
  logic [31:0]            stamp_q [ButtonCount];
  logic [ButtonCount-1:0] raw;
  logic [ButtonCount-1:0] change;

  // decode both phases into button bits
  always_comb begin
    raw[3:0] = ~low_lines_i[3:0];
    raw[7:4] = high_lines_i[3:0];
    raw[8]   = ~low_lines_i[4];
    raw[9]   = high_lines_i[4];
    if (diode_fix_i && raw[8] && raw[9]) begin
      raw[9] = 1'b0;
    end
  end

  // per-button lockout test, elapsed time wraps modulo 2^32
  always_comb begin
    for (int k = 0; k < ButtonCount; k++) begin
      change[k] = (state_q[k] != raw[k]) &&
                  ((now_ms_i - stamp_q[k]) > {16'd0, debounce_ms_i});
    end
    state_d = (state_q & ~change) | (raw & change);
  end

  assign batch_o.mask  = change;
  assign batch_o.value = raw;

  // state update on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      for (int k = 0; k < ButtonCount; k++) begin
        stamp_q[k] <= '0;
      end
    end else if (commit_i) begin
      state_q <= state_d;
      for (int k = 0; k < ButtonCount; k++) begin
        if (change[k]) begin
          stamp_q[k] <= now_ms_i;
        end
      end
    end
  end

endmodule

### rtl/dpd_emit.sv
// event emitter: pending change mask and registered result stage
// depends on dpd_pkg

module dpd_emit import dpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  evt_batch_t      batch_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [IdxW-1:0] button_index_o,
  output logic            pressed_o,
  output logic            last_o
);

  logic [ButtonCount-1:0] mask_q, mask_d;
  logic [ButtonCount-1:0] value_q, value_d;
  logic                   valid_q, valid_d;
  logic [IdxW-1:0]        index_q, index_d;
  logic                   pressed_q, pressed_d;
  logic                   last_q, last_d;
  logic [IdxW-1:0]        low_idx;
  logic [ButtonCount-1:0] remain;
  logic [ButtonCount-1:0] mask_after;
  logic                   out_free;
  logic                   pop;

  // lowest pending button
  always_comb begin
    low_idx = '0;
    for (int k = ButtonCount - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        low_idx = IdxW'(k);
      end
    end
  end

  assign remain     = mask_q & (mask_q - 1'b1);
  assign out_free   = !valid_q || out_ready_i;
  assign pop        = out_free && (mask_q != '0);
  assign mask_after = pop ? remain : mask_q;
  assign take_o     = (mask_after == '0);

  // next pending mask and result register
  always_comb begin
    mask_d    = mask_after;
    value_d   = value_q;
    valid_d   = valid_q;
    index_d   = index_q;
    pressed_d = pressed_q;
    last_d    = last_q;
    if (load_i) begin
      mask_d  = batch_i.mask;
      value_d = batch_i.value;
    end
    if (pop) begin
      valid_d   = 1'b1;
      index_d   = low_idx;
      pressed_d = value_q[low_idx];
      last_d    = (remain == '0);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    index_q   <= index_d;
    pressed_q <= pressed_d;
    last_q    <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign button_index_o = index_q;
  assign pressed_o      = pressed_q;
  assign last_o         = last_q;

endmodule

### rtl/dual_phase_pad_debouncer_core.sv
// top level of the dual-phase pad debouncer: input register, config registers
// depends on dpd_pkg, dpd_track, dpd_emit

// A scan is taken into an input register, then evaluated against the ten
// debounced button states as soon as the event emitter has no older events
// left (the last event of the previous scan may still be in the output
// register). Each changed button gives one event, lowest index first, one
// per cycle from the emitter while the output is not stalled. A scan
// occupies the emitter until its last event is handed out, so scans without
// changes flow at one per cycle. Configuration writes are always taken;
// unknown register indexes are dropped. A button changes only when its last
// accepted change lies strictly more than debounce_ms back, modulo 2^32.

module dual_phase_pad_debouncer_core import dpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // scans
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [LineCount-1:0] low_phase_lines_i,
  input  logic [LineCount-1:0] high_phase_lines_i,
  input  logic [31:0]          now_ms_i,
  // events
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IdxW-1:0]      button_index_o,
  output logic                 pressed_o,
  output logic                 last_o
);

  logic [15:0]          debounce_q;
  logic                 diode_fix_q;
  logic                 scan_valid_q;
  logic [LineCount-1:0] low_q;
  logic [LineCount-1:0] high_q;
  logic [31:0]          now_q;
  logic                 take;
  logic                 commit;
  evt_batch_t           batch;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceReset;
      diode_fix_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE_MS: debounce_q  <= cfg_data_i;
        CFG_DIODE_FIX:   diode_fix_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register, evaluated once the emitter drains
  assign commit     = scan_valid_q && take;
  assign in_ready_o = !scan_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      scan_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      low_q  <= low_phase_lines_i;
      high_q <= high_phase_lines_i;
      now_q  <= now_ms_i;
    end
  end

  // change detection and button state
  dpd_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (commit),
    .low_lines_i   (low_q),
    .high_lines_i  (high_q),
    .now_ms_i      (now_q),
    .debounce_ms_i (debounce_q),
    .diode_fix_i   (diode_fix_q),
    .batch_o       (batch)
  );

  // event serialization
  dpd_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (commit),
    .batch_i        (batch),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_index_o (button_index_o),
    .pressed_o      (pressed_o),
    .last_o         (last_o)
  );

endmodule

### sim/tb_dual_phase_pad_debouncer_core.sv
`timescale 1ns / 1ps
// testbench for dual_phase_pad_debouncer_core: directed and random scans, event checking
// depends on dpd_pkg and the dual_phase_pad_debouncer_core rtl

module tb_dual_phase_pad_debouncer_core import dpd_pkg::*;;

  // one press or release event as seen on the output port
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            pressed;
    logic            is_last;
  } btn_event_t;

  // debounced pad state and the events still owed by the block
  class debounce_predictor;
    logic [15:0]            debounce_ms;
    logic                   diode_fix;
    logic [ButtonCount-1:0] btn_state;
    logic [31:0]            stamp [ButtonCount];
    btn_event_t             pending_events [$];
    int                     errors;
    int                     scans;
    int                     events;

    function new();
      debounce_ms = DebounceReset;
      diode_fix   = 1'b0;
      btn_state   = '0;
      foreach (stamp[k]) stamp[k] = '0;
      errors = 0;
      scans  = 0;
      events = 0;
    endfunction

    // unknown register indexes are dropped
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DEBOUNCE_MS: debounce_ms = data;
        CFG_DIODE_FIX:   diode_fix   = data[0];
        default: ;
      endcase
    endfunction

    function void note_scan(logic [LineCount-1:0] low, logic [LineCount-1:0] high,
                            logic [31:0] now);
      logic [ButtonCount-1:0] raw;
      logic [31:0]            elapsed;
      btn_event_t             batch [$];
      btn_event_t             ev;
      // low phase lines are active low, high phase lines active high
      raw[3:0] = ~low[3:0];
      raw[7:4] = high[3:0];
      raw[8]   = ~low[4];
      raw[9]   = high[4];
      if (diode_fix && raw[8] && raw[9]) raw[9] = 1'b0;
      for (int k = 0; k < ButtonCount; k++) begin
        elapsed = now - stamp[k];
        if (btn_state[k] != raw[k] && elapsed > {16'd0, debounce_ms}) begin
          btn_state[k] = raw[k];
          stamp[k]     = now;
          ev.idx     = IdxW'(k);
          ev.pressed = raw[k];
          ev.is_last = 1'b0;
          batch.push_back(ev);
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].is_last = 1'b1;
      foreach (batch[i]) pending_events.push_back(batch[i]);
      scans++;
    endfunction

    function void check_event(logic [IdxW-1:0] idx, logic pressed, logic is_last);
      btn_event_t exp_ev;
      if (pending_events.size() == 0) begin
        $error("unexpected event: button_index %0d pressed %0d last %0d",
               idx, pressed, is_last);
        errors++;
        return;
      end
      exp_ev = pending_events.pop_front();
      events++;
      if (idx !== exp_ev.idx) begin
        $error("button_index mismatch: expected %0d, actual %0d", exp_ev.idx, idx);
        errors++;
      end
      if (pressed !== exp_ev.pressed) begin
        $error("pressed mismatch: expected %0d, actual %0d", exp_ev.pressed, pressed);
        errors++;
      end
      if (is_last !== exp_ev.is_last) begin
        $error("last mismatch: expected %0d, actual %0d", exp_ev.is_last, is_last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_events.size();
    endfunction
  endclass

  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 cfg_valid_i        = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i        = '0;
  logic [CfgDataW-1:0]  cfg_data_i         = '0;
  logic                 in_valid_i         = 1'b0;
  logic                 in_ready_o;
  logic [LineCount-1:0] low_phase_lines_i  = '1;
  logic [LineCount-1:0] high_phase_lines_i = '0;
  logic [31:0]          now_ms_i           = '0;
  logic                 out_valid_o;
  logic                 out_ready_i        = 1'b0;
  logic [IdxW-1:0]      button_index_o;
  logic                 pressed_o;
  logic                 last_o;

  debounce_predictor pad = new();

  bit          idle_on       = 1'b1;
  bit          long_hold_req = 1'b0;
  int          settings_used = 0;
  logic [15:0] cur_debounce  = DebounceReset;
  logic [31:0] cur_ms        = '0;

  dual_phase_pad_debouncer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .low_phase_lines_i  (low_phase_lines_i),
    .high_phase_lines_i (high_phase_lines_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .button_index_o     (button_index_o),
    .pressed_o          (pressed_o),
    .last_o             (last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // event monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      pad.check_event(button_index_o, pressed_o, last_o);
  end

  // event receiver: random stall bursts plus one long hold on request
  initial begin : receiver
    int burst;
    int hold;
    burst = 0;
    hold  = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold = 200;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (burst > 0) begin
        out_ready_i <= 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        burst = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("dual_phase_pad_debouncer_core test failed");
    $finish;
  end

  // one scan transfer, with an optional idle burst in front
  task automatic send_scan(logic [LineCount-1:0] low, logic [LineCount-1:0] high,
                           logic [31:0] now);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    low_phase_lines_i  <= low;
    high_phase_lines_i <= high;
    now_ms_i           <= now;
    do @(posedge clk_i); while (!in_ready_o);
    pad.note_scan(low, high, now);
  endtask

  task automatic stop_scans();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // wait for every owed event, then let in-flight scans without events retire
  task automatic settle();
    while (pad.outstanding() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    pad.write_reg(idx, data);
    if (idx == CFG_DEBOUNCE_MS) cur_debounce = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(logic [15:0] debounce, logic diode);
    stop_scans();
    settle();
    write_reg(CFG_DEBOUNCE_MS, debounce);
    write_reg(CFG_DIODE_FIX, {15'd0, diode});
    settings_used++;
  endtask

  // random scan: mostly changes spaced past the debounce time, some bounce and jumps
  task automatic random_scan();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5)
      cur_ms = cur_ms + {16'd0, cur_debounce} + $urandom_range(1, 20);
    else if (sel <= 7)
      cur_ms = cur_ms + $urandom_range(0, cur_debounce);
    else if (sel == 8)
      cur_ms = $urandom;
    send_scan(LineCount'($urandom_range(0, 31)), LineCount'($urandom_range(0, 31)), cur_ms);
  endtask

  // main sequence
  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, written explicitly
    set_mode(16'd50, 1'b0);
    send_scan(5'h00, 5'h1f, 32'd10);     // too early, nothing changes
    send_scan(5'h00, 5'h1f, 32'd50);     // exactly at the limit, still refused
    send_scan(5'h00, 5'h1f, 32'd51);     // all ten pressed
    send_scan(5'h1f, 5'h00, 32'd60);     // bounce back
    send_scan(5'h1f, 5'h00, 32'd101);
    send_scan(5'h1f, 5'h00, 32'd102);    // all ten released
    send_scan(5'h0f, 5'h10, 32'd200);    // buttons eight and nine together
    send_scan(5'h1f, 5'h00, 32'd300);

    // diode fix on, and a write to a register that does not exist
    set_mode(16'd50, 1'b1);
    write_reg(CfgIdxW'($urandom_range(2, 255)), CfgDataW'($urandom));
    send_scan(5'h0f, 5'h10, 32'd400);    // nine is masked
    send_scan(5'h1f, 5'h10, 32'd500);    // nine alone passes

    // zero debounce refuses only a repeated stamp
    set_mode(16'd0, 1'b1);
    send_scan(5'h0f, 5'h10, 32'd500);
    send_scan(5'h0f, 5'h10, 32'd501);

    // widest debounce with the clock wrapping around
    set_mode(16'hffff, 1'b0);
    send_scan(5'h1f, 5'h00, 32'hffff_fff0);
    send_scan(5'h1e, 5'h00, 32'h0000_0005);
    send_scan(5'h1f, 5'h00, 32'h0000_000a);
    send_scan(5'h15, 5'h0a, 32'h8000_0000);
    send_scan(5'h0a, 5'h15, 32'h7fff_ffff);
    cur_ms = 32'h0000_1000;

    // random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_mode(16'd3, 1'b0);
        1: set_mode(16'd0, 1'b1);
        2: set_mode(16'hffff, 1'b0);
        3: set_mode(16'($urandom_range(0, 200)), 1'($urandom_range(0, 1)));
        default: set_mode(16'd10, 1'b1);
      endcase
      if (ph == 1) long_hold_req = 1'b1;
      if (ph == 4) idle_on = 1'b0;
      for (int n = 0; n < 21; n++) begin
        if (ph == 0 && n == 12) begin
          stop_scans();
          while (pad.outstanding() != 0) @(negedge clk_i);
        end
        random_scan();
      end
    end

    stop_scans();
    settle();
    repeat (20) @(negedge clk_i);

    $display("ran %0d scans and checked %0d events over %0d register settings",
             pad.scans, pad.events, settings_used);
    $display("covered debounce limits, zero and widest debounce, diode fix and time wrap");
    if (pad.errors == 0) begin
      $display("dual_phase_pad_debouncer_core test passed");
    end else begin
      $display("dual_phase_pad_debouncer_core test failed");
    end
    $finish;
  end

endmodule
